@@ rtl/core/cfl_pkg.sv @@
// Shared types, constants and codes of the CFL / Fourier time step estimator.
package cfl_pkg;

  localparam int DIMENSIONS = 3;

  localparam int VEL_W   = 24;
  localparam int SQ_W    = 48;
  localparam int NORM_W  = 50;
  localparam int ROOT_W  = 25;
  localparam int REM_W   = 28;
  localparam int WIDE_W  = 104;
  localparam int DIVR_W  = 32;
  localparam int LIM_W   = 33;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int CNT_W   = 7;

  localparam int ROOT_STEPS = 25;
  localparam int DEN_STEPS  = 32;
  localparam int DIF_STEPS  = 24;
  localparam int DIV_STEPS  = 104;

  localparam logic [1:0] AXIS_LAST = 2'(DIMENSIONS - 1);

  // register indexes
  localparam logic [CFG_AW-1:0] REG_DENSITY   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_VISCOSITY = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_X    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CELL_Y    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CELL_Z    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_COURANT   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DIFFUSION = 3'd6;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic                    last_cell;
  } in_word_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic        saturated;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_RINIT, ST_ROOT, ST_CLOAD, ST_CDIV, ST_CFIN,
    ST_FLOAD, ST_FMUL1, ST_FRELOAD, ST_FMUL2, ST_FDLOAD, ST_FDIV, ST_FFIN, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       sq_load;
    logic       acc_max;
    logic       clr_max;
    logic       root_init;
    logic       root_step;
    logic       best_init;
    logic       cfl_load;
    logic       fmul_init;
    logic       mul_step;
    logic       mul_reload;
    logic       fdiv_load;
    logic       div_step;
    logic       cfl_fin;
    logic       f_fin;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ rtl/core/cfl_fourier_time_step_top.sv @@
// Top level of the CFL / Fourier time step estimator.
// An ordinary cell is squared, then the max is updated; the next word is taken after.
// A last cell runs a 25-step root, then per axis two 104-step serial divisions and a 56-step
// shift-add multiply in two passes, all in the one-bit-per-cycle units.
// The result word sits in an output register; a new last cell waits only if it is still full.
// Synchronous active-low reset: registers return to 1.0, running maximum cleared, no word held.
module cfl_fourier_time_step_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cfl_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [cfl_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cfl_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cfl_pkg::out_word_t            out_data
);

  cfl_pkg::cmd_t    cmd;
  cfl_pkg::status_t stat;

  cfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_cell),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/cfl_ctrl.sv @@
// Sequencer for accumulation, square root, multiplies and divisions per axis.
module cfl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  cfl_pkg::status_t stat,
  output cfl_pkg::cmd_t    cmd
);

  cfl_pkg::state_t               state_r, state_nxt;
  logic [cfl_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]                    axis_r, axis_nxt;
  logic                          last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfl_pkg::ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
    axis_nxt  = axis_r;
    last_nxt  = last_r;
    case (state_r)
      cfl_pkg::ST_IDLE: begin
        if (in_valid) begin
          last_nxt  = in_last;
          state_nxt = cfl_pkg::ST_ACC;
        end
      end
      cfl_pkg::ST_ACC:   state_nxt = last_r ? cfl_pkg::ST_RINIT : cfl_pkg::ST_IDLE;
      cfl_pkg::ST_RINIT: begin
        cnt_nxt   = cfl_pkg::CNT_W'(cfl_pkg::ROOT_STEPS - 1);
        axis_nxt  = '0;
        state_nxt = cfl_pkg::ST_ROOT;
      end
      cfl_pkg::ST_ROOT:  if (cnt_r == '0) state_nxt = cfl_pkg::ST_CLOAD;
      cfl_pkg::ST_CLOAD: begin
        cnt_nxt   = cfl_pkg::CNT_W'(cfl_pkg::DIV_STEPS - 1);
        state_nxt = cfl_pkg::ST_CDIV;
      end
      cfl_pkg::ST_CDIV:  if (cnt_r == '0) state_nxt = cfl_pkg::ST_CFIN;
      cfl_pkg::ST_CFIN:  state_nxt = cfl_pkg::ST_FLOAD;
      cfl_pkg::ST_FLOAD: begin
        cnt_nxt   = cfl_pkg::CNT_W'(cfl_pkg::DEN_STEPS - 1);
        state_nxt = cfl_pkg::ST_FMUL1;
      end
      cfl_pkg::ST_FMUL1: if (cnt_r == '0) state_nxt = cfl_pkg::ST_FRELOAD;
      cfl_pkg::ST_FRELOAD: begin
        cnt_nxt   = cfl_pkg::CNT_W'(cfl_pkg::DIF_STEPS - 1);
        state_nxt = cfl_pkg::ST_FMUL2;
      end
      cfl_pkg::ST_FMUL2: if (cnt_r == '0) state_nxt = cfl_pkg::ST_FDLOAD;
      cfl_pkg::ST_FDLOAD: begin
        cnt_nxt   = cfl_pkg::CNT_W'(cfl_pkg::DIV_STEPS - 1);
        state_nxt = cfl_pkg::ST_FDIV;
      end
      cfl_pkg::ST_FDIV:  if (cnt_r == '0) state_nxt = cfl_pkg::ST_FFIN;
      cfl_pkg::ST_FFIN: begin
        if (axis_r == cfl_pkg::AXIS_LAST) begin
          state_nxt = cfl_pkg::ST_EMIT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = cfl_pkg::ST_CLOAD;
        end
      end
      cfl_pkg::ST_EMIT:  if (!stat.out_busy) state_nxt = cfl_pkg::ST_IDLE;
      default:           state_nxt = cfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    in_ready = 1'b0;
    case (state_r)
      cfl_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.sq_load = in_valid;
      end
      cfl_pkg::ST_ACC:     cmd.acc_max = 1'b1;
      cfl_pkg::ST_RINIT: begin
        cmd.root_init = 1'b1;
        cmd.best_init = 1'b1;
      end
      cfl_pkg::ST_ROOT:    cmd.root_step  = 1'b1;
      cfl_pkg::ST_CLOAD:   cmd.cfl_load   = 1'b1;
      cfl_pkg::ST_CDIV:    cmd.div_step   = 1'b1;
      cfl_pkg::ST_CFIN:    cmd.cfl_fin    = 1'b1;
      cfl_pkg::ST_FLOAD:   cmd.fmul_init  = 1'b1;
      cfl_pkg::ST_FMUL1:   cmd.mul_step   = 1'b1;
      cfl_pkg::ST_FRELOAD: cmd.mul_reload = 1'b1;
      cfl_pkg::ST_FMUL2:   cmd.mul_step   = 1'b1;
      cfl_pkg::ST_FDLOAD:  cmd.fdiv_load  = 1'b1;
      cfl_pkg::ST_FDIV:    cmd.div_step   = 1'b1;
      cfl_pkg::ST_FFIN:    cmd.f_fin      = 1'b1;
      cfl_pkg::ST_EMIT: begin
        cmd.out_load = !stat.out_busy;
        cmd.clr_max  = !stat.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/cfl_datapath.sv @@
// Datapath: config registers, squared-norm max, serial root, multiplier, divider, output word.
module cfl_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cfl_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [cfl_pkg::CFG_DW-1:0]    cfg_wdata,
  input  cfl_pkg::in_word_t             in_data,
  input  cfl_pkg::cmd_t                 cmd,
  output cfl_pkg::status_t              stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cfl_pkg::out_word_t            out_data
);

  logic [31:0] density_r, viscosity_r;
  logic [23:0] cell_x_r, cell_y_r, cell_z_r, courant_r, diffusion_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_r   <= 32'h0001_0000;
      viscosity_r <= 32'h0001_0000;
      cell_x_r    <= 24'h01_0000;
      cell_y_r    <= 24'h01_0000;
      cell_z_r    <= 24'h01_0000;
      courant_r   <= 24'h01_0000;
      diffusion_r <= 24'h01_0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        cfl_pkg::REG_DENSITY:   density_r   <= cfg_wdata;
        cfl_pkg::REG_VISCOSITY: viscosity_r <= cfg_wdata;
        cfl_pkg::REG_CELL_X:    cell_x_r    <= cfg_wdata[23:0];
        cfl_pkg::REG_CELL_Y:    cell_y_r    <= cfg_wdata[23:0];
        cfl_pkg::REG_CELL_Z:    cell_z_r    <= cfg_wdata[23:0];
        cfl_pkg::REG_COURANT:   courant_r   <= cfg_wdata[23:0];
        cfl_pkg::REG_DIFFUSION: diffusion_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // magnitude of -2^23 comes out as 2^23 in 24 unsigned bits
  function automatic logic [23:0] mag(input logic signed [23:0] v);
    mag = v[23] ? (~v + 24'd1) : v;
  endfunction

  logic [cfl_pkg::SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [cfl_pkg::NORM_W-1:0] max_r, nsq;
  logic [23:0]                mx, my, mz;

  assign mx  = mag(in_data.vel_x);
  assign my  = mag(in_data.vel_y);
  assign mz  = mag(in_data.vel_z);
  assign nsq = {2'b0, sqx_r} + {2'b0, sqy_r}
             + ((cfl_pkg::DIMENSIONS >= 3) ? {2'b0, sqz_r} : '0);

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sqx_r <= mx * mx;
      sqy_r <= my * my;
      sqz_r <= mz * mz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (cmd.clr_max) begin
      max_r <= '0;
    end else if (cmd.acc_max && nsq > max_r) begin
      max_r <= nsq;
    end
  end

  // square root, one result bit per cycle
  logic [cfl_pkg::NORM_W-1:0] rx_r;
  logic [cfl_pkg::REM_W-1:0]  rem_r, rem_sh, trial;
  logic [cfl_pkg::ROOT_W-1:0] root_r, vmax;

  assign rem_sh = {rem_r[cfl_pkg::REM_W-3:0], rx_r[cfl_pkg::NORM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign vmax   = (root_r == '0) ? cfl_pkg::ROOT_W'(1) : root_r;

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rx_r   <= max_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rx_r <= {rx_r[cfl_pkg::NORM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[cfl_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[cfl_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  logic [23:0] cell_sz;
  always_comb begin
    case (cmd.axis)
      2'd0:    cell_sz = cell_x_r;
      2'd1:    cell_sz = cell_y_r;
      default: cell_sz = cell_z_r;
    endcase
  end

  logic [47:0] cell_sq, cell_co;
  assign cell_sq = cell_sz * cell_sz;
  assign cell_co = cell_sz * courant_r;

  // shift-add multiplier
  logic [cfl_pkg::WIDE_W-1:0] ma_r, acc_r;
  logic [31:0]                mb_r;

  always_ff @(posedge clk) begin
    if (cmd.fmul_init) begin
      ma_r  <= {56'b0, cell_sq};
      mb_r  <= density_r;
      acc_r <= '0;
    end else if (cmd.mul_reload) begin
      ma_r  <= acc_r;
      mb_r  <= {8'b0, diffusion_r};
      acc_r <= '0;
    end else if (cmd.mul_step) begin
      if (mb_r[0]) acc_r <= acc_r + ma_r;
      ma_r <= {ma_r[cfl_pkg::WIDE_W-2:0], 1'b0};
      mb_r <= {1'b0, mb_r[31:1]};
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [cfl_pkg::WIDE_W-1:0] dn_r, dq_r;
  logic [cfl_pkg::DIVR_W-1:0] dd_r;
  logic [cfl_pkg::DIVR_W:0]   dr_r, dr_sh;
  logic                       dfit;

  assign dr_sh = {dr_r[cfl_pkg::DIVR_W-1:0], dn_r[cfl_pkg::WIDE_W-1]};
  assign dfit  = dr_sh >= {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (cmd.cfl_load) begin
      dn_r <= {56'b0, cell_co};
      dd_r <= {7'b0, vmax};
      dr_r <= '0;
      dq_r <= '0;
    end else if (cmd.fdiv_load) begin
      dn_r <= acc_r;
      dd_r <= viscosity_r;
      dr_r <= '0;
      dq_r <= '0;
    end else if (cmd.div_step) begin
      dn_r <= {dn_r[cfl_pkg::WIDE_W-2:0], 1'b0};
      dr_r <= dfit ? dr_sh - {1'b0, dd_r} : dr_sh;
      dq_r <= {dq_r[cfl_pkg::WIDE_W-2:0], dfit};
    end
  end

  // limits carry an overflow bit on top: 2^32 stands for "does not fit"
  logic [cfl_pkg::LIM_W-1:0] best_r, cfl_lim, f_lim, new_lim;

  assign cfl_lim = (|dq_r[103:32]) ? {1'b1, 32'b0} : {1'b0, dq_r[31:0]};
  assign f_lim   = (viscosity_r == '0 || |dq_r[103:64]) ? {1'b1, 32'b0}
                                                        : {1'b0, dq_r[63:32]};
  assign new_lim = cmd.cfl_fin ? cfl_lim : f_lim;

  always_ff @(posedge clk) begin
    if (cmd.best_init) begin
      best_r <= {1'b1, 32'b0};
    end else if ((cmd.cfl_fin || cmd.f_fin) && new_lim < best_r) begin
      best_r <= new_lim;
    end
  end

  logic               out_valid_r;
  cfl_pkg::out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.time_step <= best_r[32] ? 32'hFFFF_FFFF : best_r[31:0];
      out_data_r.saturated <= best_r[32];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.out_busy = out_valid_r;

endmodule
